// ===== src/lrit_pkg.sv =====
// Shared types, constants and step functions for the line reprojection inlier test.
`default_nettype none
package lrit_pkg;

    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
    localparam logic [63:0] ERR_MAX     = 64'h0000_0000_8000_0000;
    localparam int          SQRT_STEPS  = 32;
    localparam int          DIV_STEPS   = 31;
    localparam logic [5:0]  BS_TOP_BIT  = 6'd29;
    localparam int          UNIT_STAGES = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int          ERR_STAGES  = 3 + SQRT_STEPS + 1;

    typedef enum logic [2:0] {
        REG_P0_C01,
        REG_P0_C23,
        REG_P1_C01,
        REG_P1_C23,
        REG_P2_C01,
        REG_P2_C23,
        REG_THRESH
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] image_start_x;
        logic signed [31:0] image_start_y;
        logic signed [31:0] image_end_x;
        logic signed [31:0] image_end_y;
        logic signed [31:0] world_start_x;
        logic signed [31:0] world_start_y;
        logic signed [31:0] world_start_z;
        logic signed [31:0] world_end_x;
        logic signed [31:0] world_end_y;
        logic signed [31:0] world_end_z;
    } t_in_item;

    typedef struct packed {
        logic [31:0] line_error;
        logic        inlier;
    } t_out_item;

    typedef struct packed {
        logic [5:0][63:0] proj;
        logic [31:0]      threshold;
    } t_cfg;

    typedef logic signed [63:0] t_wvec [0:2];
    typedef logic signed [31:0] t_vec [0:2];

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
    } t_usd;

    typedef struct packed {
        logic [2:0][31:0] rem;
        logic [2:0][30:0] low;
        logic [2:0][30:0] quo;
        logic [31:0]      den;
        logic [2:0]       neg;
        logic             zero;
    } t_div;

    // One digit of the bit-pair square root.
    function automatic t_sqrt sqrt_step(t_sqrt s, logic [63:0] b);
        t_sqrt       o;
        logic [63:0] t;
        t = s.root + b;
        if (s.rem >= t) begin
            o.rem  = s.rem - t;
            o.root = (s.root >> 1) + b;
        end else begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    // One quotient bit of three restoring divisions sharing a divisor.
    function automatic t_div div_step(t_div d);
        t_div        o;
        logic [32:0] t;
        o = d;
        for (int i = 0; i < 3; i++) begin
            t = {d.rem[i], d.low[i][30]};
            o.low[i] = {d.low[i][29:0], 1'b0};
            if (t >= {1'b0, d.den}) begin
                o.rem[i] = 32'(t - {1'b0, d.den});
                o.quo[i] = {d.quo[i][29:0], 1'b1};
            end else begin
                o.rem[i] = t[31:0];
                o.quo[i] = {d.quo[i][29:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== src/line_reprojection_inlier_test.sv =====
// Top level of the line reprojection inlier test.
// Each request is one line match; the block accepts one per clock while o_in_ready is high and
// returns one result per request, in order. The depth is set by the bit-per-stage square roots
// (32 stages each) and the 31-stage divider that normalizes the two line normals; the
// projection and cross products take ten stages in front. The whole pipeline advances together;
// a two-entry output buffer keeps accepting while a result waits, until its skid entry fills.
// The user must write the projection matrix and threshold over APB only while no request is in
// flight; the block itself does not enforce it. There is no clearing pass after reset.
`default_nettype none
module line_reprojection_inlier_test
    import lrit_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    t_cfg      cfg;
    logic      en;
    logic      fr_valid;
    t_vec      fr_img;
    t_vec      fr_wld;
    logic      ui_valid;
    t_vec      ui_vec;
    logic      uw_valid;
    t_vec      uw_vec;
    logic      er_valid;
    t_out_item er_item;
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      take;

    assign en         = !r_skid_valid;
    assign o_in_ready = en;
    assign take       = !r_out_valid || i_out_ready;

    lrit_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .o_cfg(cfg)
    );

    lrit_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid),
        .i_item(i_in_data), .i_cfg(cfg), .o_valid(fr_valid), .o_img(fr_img), .o_wld(fr_wld)
    );

    lrit_unit u_unit_img (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(fr_valid),
        .i_vec(fr_img), .o_valid(ui_valid), .o_vec(ui_vec)
    );

    lrit_unit u_unit_wld (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(fr_valid),
        .i_vec(fr_wld), .o_valid(uw_valid), .o_vec(uw_vec)
    );

    lrit_err u_err (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(ui_valid && uw_valid),
        .i_img(ui_vec), .i_wld(uw_vec), .i_threshold(cfg.threshold),
        .o_valid(er_valid), .o_item(er_item)
    );

    // A result that arrives while the output register is held goes to the skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= er_valid;
            end
        end else if (er_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_valid ? r_skid : er_item;
        end else if (en) begin
            r_skid <= er_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== src/lrit_cfg.sv =====
// APB register file holding the projection matrix and the error threshold.
`default_nettype none
module lrit_cfg
    import lrit_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [5:0][63:0] r_proj;
    logic [31:0]      r_thresh;
    t_reg_idx         idx;

    assign idx    = t_reg_idx'(paddr[5:3]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj   <= '0;
            r_thresh <= Q30_ONE;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_P0_C01: r_proj[0] <= pwdata;
                REG_P0_C23: r_proj[1] <= pwdata;
                REG_P1_C01: r_proj[2] <= pwdata;
                REG_P1_C23: r_proj[3] <= pwdata;
                REG_P2_C01: r_proj[4] <= pwdata;
                REG_P2_C23: r_proj[5] <= pwdata;
                REG_THRESH: r_thresh  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_P0_C01: prdata = r_proj[0];
            REG_P0_C23: prdata = r_proj[1];
            REG_P1_C01: prdata = r_proj[2];
            REG_P1_C23: prdata = r_proj[3];
            REG_P2_C01: prdata = r_proj[4];
            REG_P2_C23: prdata = r_proj[5];
            REG_THRESH: prdata = {32'd0, r_thresh};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.proj      = r_proj;
    assign o_cfg.threshold = r_thresh;

endmodule
`default_nettype wire

// ===== src/lrit_bscale.sv =====
// Three-stage block scaling of a vector so its largest magnitude has its top bit at bit 29.
`default_nettype none
module lrit_bscale
    import lrit_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_wvec i_vec,
    output t_vec       o_vec
);

    t_wvec       r_va;
    t_wvec       r_vb;
    t_vec        r_vc;
    logic [63:0] r_or;
    logic        r_right;
    logic [5:0]  r_amt;
    logic [63:0] mag_or;
    logic [5:0]  msb;

    always_comb begin
        mag_or = '0;
        for (int i = 0; i < 3; i++) begin
            mag_or = mag_or | (i_vec[i][63] ? 64'(-i_vec[i]) : 64'(i_vec[i]));
        end
    end

    // The top bit of the OR of the magnitudes is the top bit of the largest one.
    always_comb begin
        msb = '0;
        for (int i = 0; i < 64; i++) begin
            if (r_or[i]) msb = 6'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_va    <= i_vec;
            r_or    <= mag_or;
            r_vb    <= r_va;
            r_right <= msb > BS_TOP_BIT;
            r_amt   <= (msb > BS_TOP_BIT) ? msb - BS_TOP_BIT : BS_TOP_BIT - msb;
            for (int i = 0; i < 3; i++) begin
                if (r_right) begin
                    r_vc[i] <= 32'(r_vb[i] >>> r_amt);
                end else begin
                    r_vc[i] <= 32'(r_vb[i] <<< r_amt);
                end
            end
        end
    end

    assign o_vec = r_vc;

endmodule
`default_nettype wire

// ===== src/lrit_front.sv =====
// Projection, image and world cross products, and block scaling of both line vectors.
`default_nettype none
module lrit_front
    import lrit_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output logic          o_valid,
    output t_vec          o_img,
    output t_vec          o_wld
);

    localparam int STAGES = 10;
    localparam int IMG_DLY = 5;

    logic signed [31:0] pm [0:2][0:3];
    logic signed [31:0] wp [0:1][0:2];
    logic signed [63:0] r_pj [0:1][0:2][0:2];
    logic signed [63:0] r_ia;
    logic signed [63:0] r_ib;
    logic signed [32:0] r_i0;
    logic signed [32:0] r_i1;
    t_wvec              r_ps;
    t_wvec              r_pe;
    t_wvec              r_img;
    t_vec               ps_bs;
    t_vec               pe_bs;
    t_vec               img_bs;
    logic signed [63:0] r_cx [0:2][0:1];
    t_wvec              r_wc;
    t_vec               r_imgd [0:IMG_DLY-1];
    logic [STAGES-1:0]  r_v;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            pm[r][0] = i_cfg.proj[2*r][63:32];
            pm[r][1] = i_cfg.proj[2*r][31:0];
            pm[r][2] = i_cfg.proj[2*r+1][63:32];
            pm[r][3] = i_cfg.proj[2*r+1][31:0];
        end
        wp[0][0] = i_item.world_start_x;
        wp[0][1] = i_item.world_start_y;
        wp[0][2] = i_item.world_start_z;
        wp[1][0] = i_item.world_end_x;
        wp[1][1] = i_item.world_end_y;
        wp[1][2] = i_item.world_end_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < 2; p++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_pj[p][r][c] <= pm[r][c] * wp[p][c];
                    end
                end
            end
            r_ia <= i_item.image_start_x * i_item.image_end_y;
            r_ib <= i_item.image_start_y * i_item.image_end_x;
            r_i0 <= 33'(i_item.image_start_y) - 33'(i_item.image_end_y);
            r_i1 <= 33'(i_item.image_end_x) - 33'(i_item.image_start_x);

            for (int r = 0; r < 3; r++) begin
                r_ps[r] <= (r_pj[0][r][0] >>> 16) + (r_pj[0][r][1] >>> 16)
                         + (r_pj[0][r][2] >>> 16) + 64'(pm[r][3]);
                r_pe[r] <= (r_pj[1][r][0] >>> 16) + (r_pj[1][r][1] >>> 16)
                         + (r_pj[1][r][2] >>> 16) + 64'(pm[r][3]);
            end
            r_img[0] <= 64'(r_i0);
            r_img[1] <= 64'(r_i1);
            r_img[2] <= (r_ia >>> 16) - (r_ib >>> 16);

            r_cx[0][0] <= ps_bs[1] * pe_bs[2];
            r_cx[0][1] <= ps_bs[2] * pe_bs[1];
            r_cx[1][0] <= ps_bs[2] * pe_bs[0];
            r_cx[1][1] <= ps_bs[0] * pe_bs[2];
            r_cx[2][0] <= ps_bs[0] * pe_bs[1];
            r_cx[2][1] <= ps_bs[1] * pe_bs[0];
            for (int i = 0; i < 3; i++) begin
                r_wc[i] <= r_cx[i][0] - r_cx[i][1];
            end

            // The image normal waits for the world cross product and its scaling.
            r_imgd[0] <= img_bs;
            for (int k = 1; k < IMG_DLY; k++) begin
                r_imgd[k] <= r_imgd[k-1];
            end
        end
    end

    lrit_bscale u_bs_ps (.i_clk(i_clk), .i_en(i_en), .i_vec(r_ps), .o_vec(ps_bs));
    lrit_bscale u_bs_pe (.i_clk(i_clk), .i_en(i_en), .i_vec(r_pe), .o_vec(pe_bs));
    lrit_bscale u_bs_img (.i_clk(i_clk), .i_en(i_en), .i_vec(r_img), .o_vec(img_bs));
    lrit_bscale u_bs_wc (.i_clk(i_clk), .i_en(i_en), .i_vec(r_wc), .o_vec(o_wld));

    assign o_img   = r_imgd[IMG_DLY-1];
    assign o_valid = r_v[STAGES-1];

endmodule
`default_nettype wire

// ===== src/lrit_unit.sv =====
// Pipelined normalization of a scaled vector to unit length in Q2.30.
`default_nettype none
module lrit_unit
    import lrit_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_vec i_vec,
    output logic      o_valid,
    output t_vec      o_vec
);

    t_usd                   r_sd0;
    t_usd                   r_sd1;
    t_usd                   r_sd2;
    logic [61:0]            r_sqr [0:2];
    logic [61:0]            r_sum;
    t_sqrt                  r_sq [0:SQRT_STEPS-1];
    t_usd                   r_sqsd [0:SQRT_STEPS-1];
    t_div                   r_dv [0:DIV_STEPS];
    t_vec                   r_out;
    logic [UNIT_STAGES-1:0] r_v;
    t_sqrt                  sq_in;
    t_div                   dv_in;
    logic [31:0]            nrm;
    logic [60:0]            num;

    always_comb begin
        sq_in.rem  = 64'(r_sum);
        sq_in.root = '0;
    end

    // Rounded quotient: (|c| * 2^30 + n/2) / n, top quotient bits known to be zero.
    always_comb begin
        nrm         = r_sq[SQRT_STEPS-1].root[31:0];
        dv_in.den   = nrm;
        dv_in.neg   = r_sqsd[SQRT_STEPS-1].neg;
        dv_in.zero  = (nrm == '0);
        dv_in.quo   = '0;
        num         = '0;
        for (int i = 0; i < 3; i++) begin
            num          = {r_sqsd[SQRT_STEPS-1].mag[i], 30'd0} + 61'(nrm >> 1);
            dv_in.rem[i] = {2'b00, num[60:31]};
            dv_in.low[i] = num[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[UNIT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sd0.mag[i] <= i_vec[i][31] ? 31'(-i_vec[i]) : 31'(i_vec[i]);
                r_sd0.neg[i] <= i_vec[i][31];
                r_sqr[i]     <= r_sd0.mag[i] * r_sd0.mag[i];
            end
            r_sd1 <= r_sd0;
            r_sum <= r_sqr[0] + r_sqr[1] + r_sqr[2];
            r_sd2 <= r_sd1;

            r_sq[0]   <= sqrt_step(sq_in, 64'd1 << 62);
            r_sqsd[0] <= r_sd2;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_sq[k]   <= sqrt_step(r_sq[k-1], 64'd1 << (62 - 2*k));
                r_sqsd[k] <= r_sqsd[k-1];
            end

            r_dv[0] <= dv_in;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dv[k] <= div_step(r_dv[k-1]);
            end

            for (int i = 0; i < 3; i++) begin
                if (r_dv[DIV_STEPS].zero) begin
                    r_out[i] <= '0;
                end else if (r_dv[DIV_STEPS].quo[i] > 31'(Q30_ONE)) begin
                    r_out[i] <= r_dv[DIV_STEPS].neg[i] ? -$signed(Q30_ONE) : $signed(Q30_ONE);
                end else begin
                    r_out[i] <= r_dv[DIV_STEPS].neg[i] ? -32'(r_dv[DIV_STEPS].quo[i])
                                                       : 32'(r_dv[DIV_STEPS].quo[i]);
                end
            end
        end
    end

    assign o_vec   = r_out;
    assign o_valid = r_v[UNIT_STAGES-1];

endmodule
`default_nettype wire

// ===== src/lrit_err.sv =====
// Distance between the two unit normals, saturation and the threshold test.
`default_nettype none
module lrit_err
    import lrit_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_vec        i_img,
    input  wire t_vec        i_wld,
    input  wire logic [31:0] i_threshold,
    output logic             o_valid,
    output t_out_item        o_item
);

    logic signed [32:0]    dif [0:2];
    logic [31:0]           r_dm [0:2];
    logic [63:0]           r_dsq [0:2];
    logic [63:0]           r_esum;
    t_sqrt                 r_sq [0:SQRT_STEPS-1];
    t_out_item             r_item;
    logic [ERR_STAGES-1:0] r_v;
    t_sqrt                 sq_in;
    logic [31:0]           err;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dif[i] = 33'(i_img[i]) - 33'(i_wld[i]);
        end
        sq_in.rem  = r_esum;
        sq_in.root = '0;
        err = (r_sq[SQRT_STEPS-1].root > ERR_MAX) ? ERR_MAX[31:0]
                                                  : r_sq[SQRT_STEPS-1].root[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ERR_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dm[i]  <= dif[i][32] ? 32'(-dif[i]) : 32'(dif[i]);
                r_dsq[i] <= r_dm[i] * r_dm[i];
            end
            r_esum  <= r_dsq[0] + r_dsq[1] + r_dsq[2];
            r_sq[0] <= sqrt_step(sq_in, 64'd1 << 62);
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_sq[k] <= sqrt_step(r_sq[k-1], 64'd1 << (62 - 2*k));
            end
            r_item.line_error <= err;
            r_item.inlier     <= err < i_threshold;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_v[ERR_STAGES-1];

endmodule
`default_nettype wire

// ===== src/lrit_check.sv =====
// Port-level checker for the line reprojection inlier test and its bind.
`default_nettype none
module lrit_check
    import lrit_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire t_out_item   o_out_data
);

    logic [7:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Requests accepted whose results have not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 8'd1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 8'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 64'(o_out_data.line_error) <= ERR_MAX)
        else $error("line error above saturation");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 8'd0)
        else $error("result without a pending request");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind line_reprojection_inlier_test lrit_check u_check (.*);
`default_nettype wire

// ===== verif/tb_line_reprojection_inlier_test.sv =====
// Testbench for the line reprojection inlier test: directed and random line matches against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_line_reprojection_inlier_test;
    import lrit_pkg::*;

    localparam int LATENCY   = 115;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1680;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    line_reprojection_inlier_test dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state: the register file as the block sees it.
    logic [63:0] proj_regs [0:5];
    logic [31:0] thresh_reg;

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] magn(logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Shift a vector so its largest magnitude lands in [2^29, 2^30).
    function automatic void normalize_range(ref logic signed [63:0] v [0:2]);
        logic [63:0] m;
        int k;
        m = 0;
        k = 0;
        for (int i = 0; i < 3; i++) if (magn(v[i]) > m) m = magn(v[i]);
        if (m == 0) return;
        while ((m >> k) >= 64'(Q30_ONE)) k++;
        if (k > 0) begin
            for (int i = 0; i < 3; i++) v[i] = floor_shift(v[i], k);
            return;
        end
        while (m < 64'(Q30_ONE >> 1)) begin
            for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
            m = m * 2;
        end
    endfunction

    function automatic void unit_normal(logic signed [63:0] v [0:2],
                                        ref logic signed [63:0] u [0:2]);
        logic [63:0] s, n, q;
        s = 0;
        normalize_range(v);
        for (int i = 0; i < 3; i++) s += magn(v[i]) * magn(v[i]);
        if (s == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return;
        end
        n = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((magn(v[i]) << 30) + n / 2) / n;
            if (q > 64'(Q30_ONE)) q = 64'(Q30_ONE);
            u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic signed [63:0] pent(int r, int c);
        logic [63:0] w;
        w = proj_regs[2 * r + c / 2];
        return (c % 2 == 0) ? 64'($signed(w[63:32])) : 64'($signed(w[31:0]));
    endfunction

    function automatic void project_point(logic signed [63:0] x, logic signed [63:0] y,
                                          logic signed [63:0] z,
                                          ref logic signed [63:0] o [0:2]);
        for (int r = 0; r < 3; r++)
            o[r] = floor_shift(pent(r, 0) * x, 16) + floor_shift(pent(r, 1) * y, 16)
                 + floor_shift(pent(r, 2) * z, 16) + pent(r, 3);
    endfunction

    function automatic t_out_item predict_line_error(t_in_item it);
        logic signed [63:0] x1, y1, x2, y2;
        logic signed [63:0] img [0:2], ps [0:2], pe [0:2], wc [0:2], ui [0:2], uw [0:2];
        logic [63:0] sum, d, e;
        t_out_item o;
        x1 = 64'(it.image_start_x);
        y1 = 64'(it.image_start_y);
        x2 = 64'(it.image_end_x);
        y2 = 64'(it.image_end_y);
        img[0] = y1 - y2;
        img[1] = x2 - x1;
        img[2] = floor_shift(x1 * y2, 16) - floor_shift(y1 * x2, 16);
        project_point(64'(it.world_start_x), 64'(it.world_start_y), 64'(it.world_start_z), ps);
        project_point(64'(it.world_end_x), 64'(it.world_end_y), 64'(it.world_end_z), pe);
        normalize_range(ps);
        normalize_range(pe);
        wc[0] = ps[1] * pe[2] - ps[2] * pe[1];
        wc[1] = ps[2] * pe[0] - ps[0] * pe[2];
        wc[2] = ps[0] * pe[1] - ps[1] * pe[0];
        unit_normal(img, ui);
        unit_normal(wc, uw);
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            d = magn(ui[i] - uw[i]);
            sum += d * d;
        end
        e = int_sqrt(sum);
        if (e > ERR_MAX) e = ERR_MAX;
        o.line_error = e[31:0];
        o.inlier = e < 64'(thresh_reg);
        return o;
    endfunction

    class line_error_board;
        t_out_item pending [$];
        int        errors;

        function void note_request(t_in_item it);
            pending = {pending, predict_line_error(it)};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.line_error !== want.line_error || got.inlier !== want.inlier) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: error exp %h got %h, inlier exp %b got %b",
                             want.line_error, got.line_error, want.inlier, got.inlier);
            end
        endfunction
    endclass

    line_error_board board = new();
    int  idle_cycles;
    bit  calm;          // no idling in the last part of the run
    int  hold_off;      // long receiver stall requested by the stimulus
    t_in_item req_q [$];

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) board.note_request(i_in_data);
            if (o_out_valid && i_out_ready) board.check_result(o_out_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off.
    initial begin : receiver
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_off) @(negedge i_clk);
                hold_off = 0;
            end
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 10);
                i_out_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(t_reg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 6'(8 * int'(idx)); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_THRESH) thresh_reg = val[31:0];
        else proj_regs[int'(idx)] = val;
    endtask

    // Request driver: valid stays high back to back unless a gap is drawn.
    task automatic send_requests();
        t_in_item it;
        int n;
        while (req_q.size() > 0) begin
            it = req_q.pop_front();
            i_in_valid <= 1'b1;
            i_in_data <= it;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 10);
                i_in_valid <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() > 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
            2: return 32'($signed($urandom_range(0, 2 * 65536 * 2048)) - 65536 * 2048);
            default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    function automatic t_in_item rnd_item();
        t_in_item it;
        logic [31:0] f [10];
        for (int i = 0; i < 10; i++) f[i] = rnd_coord();
        it = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]};
        // Sometimes a degenerate image line with both endpoints equal.
        if ($urandom_range(0, 15) == 0) begin
            it.image_end_x = it.image_start_x;
            it.image_end_y = it.image_start_y;
        end
        return it;
    endfunction

    function automatic logic [63:0] rnd_row();
        logic [31:0] a, b;
        a = rnd_coord();
        b = rnd_coord();
        return {a, b};
    endfunction

    // Camera-like matrix so projected and image normals are comparable.
    task automatic load_camera();
        cfg_write(REG_P0_C01, {32'h0001_0000, 32'h0});
        cfg_write(REG_P0_C23, {32'h0, 32'h0});
        cfg_write(REG_P1_C01, {32'h0, 32'h0001_0000});
        cfg_write(REG_P1_C23, {32'h0, 32'h0});
        cfg_write(REG_P2_C01, {32'h0, 32'h0});
        cfg_write(REG_P2_C23, {32'h0, 32'h0001_0000});
    endtask

    initial begin : stimulus
        t_in_item it;
        logic [31:0] ext [4];
        for (int i = 0; i < 6; i++) proj_regs[i] = '0;
        thresh_reg = Q30_ONE;
        calm = 0;
        hold_off = 0;
        idle_cycles = 0;
        ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset matrix is zero: every world normal is degenerate.
        for (int i = 0; i < 4; i++) begin
            it = {10{ext[i]}};
            req_q = {req_q, it};
        end
        send_requests();
        drain();

        load_camera();
        cfg_write(REG_THRESH, 32'h0);
        // Image line lying exactly on the projected world line, one with the world end x negated, and field extremes.
        it = '{image_start_x: 32'h0001_0000, image_start_y: 32'h0002_0000,
               image_end_x: 32'h0005_0000, image_end_y: 32'h0003_0000,
               world_start_x: 32'h0001_0000, world_start_y: 32'h0002_0000,
               world_start_z: 32'h0001_0000, world_end_x: 32'h0005_0000,
               world_end_y: 32'h0003_0000, world_end_z: 32'h0001_0000};
        req_q = {req_q, it};
        it.world_end_x = -it.world_end_x;
        req_q = {req_q, it};
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                it = {ext[i], ext[j], ext[j], ext[i], ext[i], ext[j], ext[i],
                      ext[j], ext[i], ext[j]};
                req_q = {req_q, it};
            end
        send_requests();
        drain();

        cfg_write(REG_THRESH, 32'hffff_ffff);
        for (int i = 0; i < 3; i++) req_q = {req_q, rnd_item()};
        send_requests();
        drain();

        // Random phases over several matrices and thresholds.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph % 2 == 0) load_camera();
            else begin
                cfg_write(REG_P0_C01, rnd_row());
                cfg_write(REG_P0_C23, rnd_row());
                cfg_write(REG_P1_C01, rnd_row());
                cfg_write(REG_P1_C23, rnd_row());
                cfg_write(REG_P2_C01, rnd_row());
                cfg_write(REG_P2_C23, rnd_row());
            end
            cfg_write(REG_THRESH, ph == 5 ? 32'h8000_0000 : $urandom_range(0, 32'h8000_0000));
            for (int i = 0; i < N_RANDOM / 6; i++) req_q = {req_q, rnd_item()};
            if (ph == 2) hold_off = 400;
            if (ph == 5) calm = 1;
            send_requests();
            drain();
        end

        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
